// ===== src/afbd_pkg.sv =====
// Package for the anchor-free box decoder: sizes, register indexes,
// the sigmoid table built at elaboration and per-stage arithmetic helpers.
// No dependencies.
package afbd_pkg;

    localparam int SIG_N  = 64;
    localparam int SIG_IW = $clog2(SIG_N + 1);
    localparam int SIG_PW = 15 + SIG_IW;

    typedef enum logic [2:0] {
        REG_THRESHOLD    = 3'd0,
        REG_STRIDE       = 3'd1,
        REG_OFFSET_MULT  = 3'd2,
        REG_CLASS_SCALE  = 3'd3,
        REG_CENTER_SCALE = 3'd4,
        REG_IMAGE_WIDTH  = 3'd5,
        REG_IMAGE_HEIGHT = 3'd6,
        REG_UNUSED       = 3'd7
    } t_reg_idx;

    typedef logic [15:0] t_sig_tab [0:SIG_N];

    // Sigmoid prep result: table points, blend weight, sign
    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic [14:0] frac;
        logic        neg;
    } t_sig_prep;

    // Square root iteration state
    typedef struct packed {
        logic [31:0] v;
        logic [17:0] rem;
        logic [15:0] q;
    } t_sqrt;

    // Shift-and-subtract quotient, evaluated only while the table is built
    function automatic logic [63:0] f_udiv(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-x in Q.30, x in Q.30: series on x/64, then six squarings
    function automatic logic [63:0] f_exp_neg(input logic [63:0] xq30);
        logic [63:0] y;
        logic [63:0] term;
        logic signed [63:0] acc;
        logic [63:0] r;
        y    = xq30 >> 6;
        term = 64'd1 << 30;
        acc  = 64'sd1 << 30;
        for (int n = 1; n <= 10; n++) begin
            term = f_udiv((term * y) >> 30, 64'(n));
            if (n[0] == 1'b1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        r = (acc > 0) ? acc : 64'd0;
        for (int n = 0; n < 6; n++) begin
            r = (r * r) >> 30;
        end
        return r;
    endfunction

    function automatic t_sig_tab f_build_sig();
        t_sig_tab    tab;
        logic [63:0] xq30;
        logic [63:0] d;
        logic [63:0] s;
        for (int i = 0; i <= SIG_N; i++) begin
            xq30 = f_udiv(64'(i) << 33, 64'(SIG_N));
            d    = (64'd1 << 30) + f_exp_neg(xq30);
            s    = f_udiv((64'd1 << 46) + (d >> 1), d);
            tab[i] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = f_build_sig();

    // Limit an edge to [0, (size-1)*16]
    function automatic logic [15:0] f_clamp(input logic signed [21:0] e,
                                            input logic [11:0] size);
        logic signed [21:0] hi;
        logic signed [21:0] v;
        hi = ($signed({10'd0, size}) - 22'sd1) <<< 4;
        v  = e;
        if (v > hi) begin
            v = hi;
        end
        if (v < 0) begin
            v = '0;
        end
        return v[15:0];
    endfunction

    // Table lookup for sigmoid of a Q.12 argument
    function automatic t_sig_prep f_sig_prep(input logic signed [24:0] x);
        t_sig_prep            p;
        logic [24:0]          mag;
        logic [SIG_PW-1:0]    pos;
        logic [SIG_IW-1:0]    idx;
        mag   = x[24] ? 25'(-x) : x;
        pos   = SIG_PW'(mag[14:0]) * SIG_PW'(SIG_N);
        idx   = pos[SIG_PW-1:15];
        p.neg = x[24];
        if (|mag[24:15]) begin
            p.lo   = SIG_TAB[SIG_N];
            p.hi   = SIG_TAB[SIG_N];
            p.frac = '0;
        end else begin
            p.lo   = SIG_TAB[idx];
            p.hi   = SIG_TAB[idx + SIG_IW'(1)];
            p.frac = pos[14:0];
        end
        return p;
    endfunction

    // Blend two table points, mirror for a negative argument
    function automatic logic [15:0] f_sig_blend(input t_sig_prep p);
        logic [31:0] acc;
        logic [16:0] s;
        acc = 32'(p.lo) * (32'd32768 - 32'(p.frac)) + 32'(p.hi) * 32'(p.frac)
            + 32'd16384;
        s = acc[31:15];
        if (p.neg) begin
            s = 17'd65536 - s;
        end
        return (s > 17'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    // Four digit steps of a restoring square root
    function automatic t_sqrt f_sqrt4(input t_sqrt st);
        t_sqrt       o;
        logic [19:0] r;
        logic [19:0] t;
        o = st;
        for (int k = 0; k < 4; k++) begin
            r = {o.rem, o.v[31:30]};
            t = {2'b00, o.q, 2'b01};
            o.v = o.v << 2;
            if (r >= t) begin
                r   = r - t;
                o.q = {o.q[14:0], 1'b1};
            end else begin
                o.q = {o.q[14:0], 1'b0};
            end
            o.rem = r[17:0];
        end
        return o;
    endfunction

endpackage

// ===== src/anchor_free_box_decode.sv =====
// Top level of the anchor-free box decoder: register file and an eight
// stage pipeline from offsets to score. Depends on afbd_pkg.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata 64b, tuser 8b
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata 80b, tuser 8b
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_addr, i_cfg_data
//
// One item per cycle unless the output stalls; each box is offered from the last stage.
// Latency is set by the sixteen digit steps of the score square root, four
// per stage, behind four stages of multiply, clamp and sigmoid table work.
// Synchronous active-low reset clears the valid bits and loads register defaults.
// A stall at the output backs up stage by stage; empty stages still fill.
// Items at or below threshold or with negative size travel as bubbles and are dropped.
module anchor_free_box_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_x, cell_y, class_logit, center_logit, off_left, off_top,
    // off_right, off_bottom
    input  logic [63:0] s_axis_tdata,
    // class_index
    input  logic [7:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // center_x, center_y, box_width, box_height, box_score
    output logic [79:0] m_axis_tdata,
    // box_class
    output logic [7:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);
    import afbd_pkg::*;

    localparam int NS = 8;

    logic signed [7:0]  r_thr;
    logic [7:0]         r_stride;
    logic [15:0]        r_omult;
    logic [15:0]        r_cscale;
    logic [15:0]        r_nscale;
    logic [11:0]        r_img_w;
    logic [11:0]        r_img_h;

    logic [NS-1:0] r_v;
    logic [NS-1:0] r_keep;
    logic [NS-1:0] rdy;

    // stage 1
    logic [15:0]        r1_px, r1_py;
    logic signed [24:0] r1_ol, r1_ot, r1_or, r1_ob, r1_pc, r1_pn;
    logic [7:0]         r1_cls;
    // stage 2
    logic [15:0]        r2_x1, r2_y1, r2_x2, r2_y2;
    t_sig_prep          r2_sc, r2_sn;
    logic [7:0]         r2_cls;
    // stage 3
    logic [15:0]        r3_cx, r3_cy, r3_w, r3_h, r3_sc, r3_sn;
    logic [7:0]         r3_cls;
    // stages 4..8 carry the box, stage 4 onward the square root state
    logic [15:0]        r_cx [4:NS], r_cy [4:NS], r_bw [4:NS], r_bh [4:NS];
    logic [7:0]         r_cls [4:NS];
    t_sqrt              r_sq [4:NS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= '0;
            r_stride <= 8'd8;
            r_omult  <= 16'd256;
            r_cscale <= 16'd4096;
            r_nscale <= 16'd4096;
            r_img_w  <= 12'd640;
            r_img_h  <= 12'd640;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_THRESHOLD:    r_thr    <= $signed(i_cfg_data[7:0]);
                REG_STRIDE:       r_stride <= i_cfg_data[7:0];
                REG_OFFSET_MULT:  r_omult  <= i_cfg_data;
                REG_CLASS_SCALE:  r_cscale <= i_cfg_data;
                REG_CENTER_SCALE: r_nscale <= i_cfg_data;
                REG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[11:0];
                REG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on
    always_comb begin
        rdy[NS-1] = !r_v[NS-1] || !r_keep[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = r_v[NS-1] && r_keep[NS-1];
    assign m_axis_tdata  = {r_sq[NS].q, r_bh[NS], r_bw[NS], r_cy[NS], r_cx[NS]};
    assign m_axis_tuser  = r_cls[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    logic signed [7:0] in_cl, in_nl, in_l, in_t, in_r, in_b;
    assign in_cl = $signed(s_axis_tdata[23:16]);
    assign in_nl = $signed(s_axis_tdata[31:24]);
    assign in_l  = $signed(s_axis_tdata[39:32]);
    assign in_t  = $signed(s_axis_tdata[47:40]);
    assign in_r  = $signed(s_axis_tdata[55:48]);
    assign in_b  = $signed(s_axis_tdata[63:56]);

    // Stage 2 combinational: location, scaled offsets, clamped edges
    logic [19:0]        lx, ly;
    logic signed [20:0] ol, ot, orr, ob;
    logic signed [24:0] rl, rt, rr, rb;
    assign lx = {r1_px + 16'(r_stride[7:1]), 4'd0};
    assign ly = {r1_py + 16'(r_stride[7:1]), 4'd0};
    assign rl = r1_ol + 25'sd8;
    assign rt = r1_ot + 25'sd8;
    assign rr = r1_or + 25'sd8;
    assign rb = r1_ob + 25'sd8;
    assign ol  = rl[24:4];
    assign ot  = rt[24:4];
    assign orr = rr[24:4];
    assign ob  = rb[24:4];

    // Stage 3 combinational: size and center
    logic signed [17:0] w, h;
    assign w = $signed({2'b00, r2_x2}) - $signed({2'b00, r2_x1}) + 18'sd16;
    assign h = $signed({2'b00, r2_y2}) - $signed({2'b00, r2_y1}) + 18'sd16;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_keep[0] <= in_cl > r_thr;
            r1_px  <= 16'(s_axis_tdata[7:0]) * 16'(r_stride);
            r1_py  <= 16'(s_axis_tdata[15:8]) * 16'(r_stride);
            r1_ol  <= 25'(in_l) * 25'($signed({1'b0, r_omult}));
            r1_ot  <= 25'(in_t) * 25'($signed({1'b0, r_omult}));
            r1_or  <= 25'(in_r) * 25'($signed({1'b0, r_omult}));
            r1_ob  <= 25'(in_b) * 25'($signed({1'b0, r_omult}));
            r1_pc  <= 25'(in_cl) * 25'($signed({1'b0, r_cscale}));
            r1_pn  <= 25'(in_nl) * 25'($signed({1'b0, r_nscale}));
            r1_cls <= s_axis_tuser;
        end
        if (rdy[1]) begin
            r_keep[1] <= r_keep[0];
            r2_x1  <= f_clamp($signed({2'b00, lx}) - 22'(ol), r_img_w);
            r2_y1  <= f_clamp($signed({2'b00, ly}) - 22'(ot), r_img_h);
            r2_x2  <= f_clamp($signed({2'b00, lx}) + 22'(orr), r_img_w);
            r2_y2  <= f_clamp($signed({2'b00, ly}) + 22'(ob), r_img_h);
            r2_sc  <= f_sig_prep(r1_pc);
            r2_sn  <= f_sig_prep(r1_pn);
            r2_cls <= r1_cls;
        end
        if (rdy[2]) begin
            // drop boxes with negative size
            r_keep[2] <= r_keep[1] && !w[17] && !h[17];
            r3_cx  <= r2_x1 + w[16:1];
            r3_cy  <= r2_y1 + h[16:1];
            r3_w   <= w[15:0];
            r3_h   <= h[15:0];
            r3_sc  <= f_sig_blend(r2_sc);
            r3_sn  <= f_sig_blend(r2_sn);
            r3_cls <= r2_cls;
        end
        if (rdy[3]) begin
            r_keep[3] <= r_keep[2];
            r_cx[4]   <= r3_cx;
            r_cy[4]   <= r3_cy;
            r_bw[4]   <= r3_w;
            r_bh[4]   <= r3_h;
            r_cls[4]  <= r3_cls;
            r_sq[4]   <= '{v: 32'(r3_sc) * 32'(r3_sn), rem: '0, q: '0};
        end
        for (int k = 4; k < NS; k++) begin
            if (rdy[k]) begin
                r_keep[k]  <= r_keep[k-1];
                r_cx[k+1]  <= r_cx[k];
                r_cy[k+1]  <= r_cy[k];
                r_bw[k+1]  <= r_bw[k];
                r_bh[k+1]  <= r_bh[k];
                r_cls[k+1] <= r_cls[k];
                r_sq[k+1]  <= f_sqrt4(r_sq[k]);
            end
        end
    end

endmodule

// ===== src/afbd_checker.sv =====
// Port-level checks for the box decoder and the bind that attaches them.
// Depends on anchor_free_box_decode ports only.
module afbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        o_cfg_ready
);

    // No box right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A waiting box holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

    // Downstream ready always lets the pipeline take an item
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output drains");

    // Configuration writes never stall
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind anchor_free_box_decode afbd_checker u_afbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .o_cfg_ready   (o_cfg_ready)
);
